### hdl/hpts_pkg.sv
package hpts_pkg;

  localparam int SYMBOL_W      = 8;
  localparam int FLANK_W       = 6;
  localparam int MINLEN_W      = 8;
  localparam int CONTEXT_W     = 64;
  localparam int HIST_BASES    = 32;
  localparam int LENGTH_W      = 16;
  localparam int OFFSET_W      = 16;
  localparam int TAG_W         = 8;
  localparam int KM1_W         = 5;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int OUT_DATA_W    = 168;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_FLANK         = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_FLANK_BASES   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TRACT_LEN = 1'd1;

  localparam logic [FLANK_W-1:0]  FLANK_BASES_RST   = 6'd25;
  localparam logic [MINLEN_W-1:0] MIN_TRACT_LEN_RST = 8'd4;
  localparam logic [MINLEN_W-1:0] MIN_TRACT_FLOOR   = 8'd2;
  localparam logic [SYMBOL_W:0]   NO_SYMBOL         = 9'h100;
  localparam logic [LENGTH_W-1:0] LENGTH_MAX        = 16'hFFFF;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef logic [CONTEXT_W-1:0]  context_t;
  typedef logic [HIST_BASES-1:0] amb_hist_t;
  typedef logic [FLANK_W-1:0]    flank_t;

  typedef struct packed {
    context_t              left;
    logic [LENGTH_W-1:0]   length;
    logic [OFFSET_W-1:0]   offset;
    logic                  base;
    logic                  rev;
    logic [TAG_W-1:0]      tag;
    logic [KM1_W-1:0]      km1;
  } entry_t;

  typedef struct packed {
    context_t              first;
    context_t              second;
    logic                  base;
    logic [LENGTH_W-1:0]   length;
    logic [OFFSET_W-1:0]   offset;
    logic                  rev;
  } result_t;

  // {ambiguous, code}
  function automatic logic [2:0] sym_decode(input logic [SYMBOL_W-1:0] s);
    logic [2:0] r;
    case (s)
      8'h41, 8'h61:               r = {1'b0, BASE_A};
      8'h43, 8'h63:               r = {1'b0, BASE_C};
      8'h47, 8'h67:               r = {1'b0, BASE_G};
      8'h54, 8'h74, 8'h55, 8'h75: r = {1'b0, BASE_T};
      default:                    r = {1'b1, BASE_A};
    endcase
    return r;
  endfunction

endpackage

### hdl/hpts_ram.sv
module hpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/hpts_window.sv
module hpts_window (
  input  hpts_pkg::context_t  hist,
  input  hpts_pkg::amb_hist_t amb,
  input  hpts_pkg::flank_t    k,
  input  logic                rev,
  output hpts_pkg::context_t  win
);
  import hpts_pkg::*;

  context_t fwd;
  context_t rc;

  assign fwd = hist >> (8'd64 - {1'b0, k, 1'b0});

  always_comb begin
    rc = '0;
    for (int i = 0; i < HIST_BASES; i++) begin
      if (FLANK_W'(i) < k) begin
        rc[2*i +: 2] = amb[HIST_BASES-1-i] ? BASE_A : ~hist[2*(HIST_BASES-1-i) +: 2];
      end
    end
  end

  assign win = rev ? rc : fwd;

endmodule

### hdl/homopolymer_tract_scanner_core.sv
// Homopolymer tract scanner. Takes one read byte per cycle and reports runs of a
// single base that are long enough and have a full K-base flank on each side.
// Words are accepted every cycle while the output side keeps up: all per-base
// work (run tracking, flank shift, FIFO head check) completes on accept, and
// tracts waiting for their right flank sit in a PENDING_DEPTH-entry RAM whose
// head is prefetched from head_next, with a write bypass for a freshly queued
// entry. A two-word output stage holds results; input ready drops only while
// both are full. A tract is emitted on the word carrying its K-th right-flank
// base; tracts still pending at the last word of a read are dropped.
module homopolymer_tract_scanner_core #(
  parameter int PENDING_DEPTH = hpts_pkg::PENDING_DEPTH_DEF,
  parameter int POSITION_BITS = hpts_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hpts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hpts_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [hpts_pkg::SYMBOL_W-1:0]      s_axis_tdata,  // symbol
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // context_first, context_second, tract_base, tract_len, flank_offset, zero pad
  output logic [hpts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [0:0]                         m_axis_tuser   // reverse_strand
);
  import hpts_pkg::*;

  localparam int AW    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW    = $clog2(PENDING_DEPTH + 1);
  localparam int POS_W = POSITION_BITS + 1;
  localparam logic [63:0] POS_LIM64 = (64'd1 << POSITION_BITS) - 64'd1;
  localparam logic [POS_W-1:0] OFF_LIM =
      (POSITION_BITS >= OFFSET_W) ? POS_W'(16'hFFFF) : POS_W'(POS_LIM64);
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(PENDING_DEPTH - 1);

  flank_t               flank_bases;
  logic [MINLEN_W-1:0]  min_tract_len;

  context_t             base_history;
  amb_hist_t            ambig_history;
  logic [POS_W-1:0]     position;
  logic [SYMBOL_W:0]    run_symbol;
  logic [LENGTH_W-1:0]  run_count;
  logic [POS_W-1:0]     run_start;
  context_t             run_left_flank;
  logic [AW-1:0]        head;
  logic [AW-1:0]        tail;
  logic [CW-1:0]        pending_count;
  logic [TAG_W-1:0]     step;
  logic                 byp_sel;
  entry_t               byp_q;
  logic [$bits(entry_t)-1:0] ram_q;

  logic                 out_valid;
  result_t              out_q;
  logic                 skid_valid;
  result_t              skid_q;

  logic                 accept;
  logic                 flush;
  logic [2:0]           dec;
  logic [2:0]           run_dec;
  logic                 amb;
  logic [1:0]           code;
  flank_t               k_eff;
  logic [MINLEN_W-1:0]  minlen;
  logic                 new_run;
  logic                 qualify;
  logic                 enq;
  logic [POS_W-1:0]     off_diff;
  entry_t               new_ent;
  entry_t               head_ent;
  logic                 head_valid;
  logic [TAG_W-1:0]     elapsed;
  logic                 pop;
  context_t             left_win;
  context_t             right_win;
  context_t             hist_next;
  amb_hist_t            amb_next;
  logic [AW-1:0]        head_next;
  logic [AW-1:0]        tail_next;
  logic [CW-1:0]        count_next;
  result_t              res;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  assign accept = s_axis_tvalid && s_axis_tready;
  assign flush  = accept && s_axis_tlast;
  assign dec    = sym_decode(s_axis_tdata);
  assign amb    = dec[2];
  assign code   = dec[1:0];
  assign run_dec = sym_decode(run_symbol[SYMBOL_W-1:0]);

  assign k_eff  = (flank_bases == '0) ? FLANK_W'(1) :
                  (flank_bases > FLANK_W'(MAX_FLANK)) ? FLANK_W'(MAX_FLANK) : flank_bases;
  assign minlen = (min_tract_len < MIN_TRACT_FLOOR) ? MIN_TRACT_FLOOR : min_tract_len;

  assign new_run = {1'b0, s_axis_tdata} != run_symbol;
  assign qualify = new_run && !run_symbol[SYMBOL_W] && !run_dec[2] &&
                   (run_count >= LENGTH_W'(minlen)) &&
                   (run_start >= POS_W'(k_eff)) &&
                   (pending_count < DEPTH_C);
  assign enq = accept && qualify;

  assign off_diff = run_start - POS_W'(k_eff);

  always_comb begin
    new_ent.left   = run_left_flank;
    new_ent.length = run_count;
    new_ent.offset = OFFSET_W'((off_diff > OFF_LIM) ? OFF_LIM : off_diff);
    new_ent.rev    = run_dec[1];
    new_ent.base   = run_dec[1] ? ~run_dec[0] : run_dec[0];
    new_ent.tag    = step;
    new_ent.km1    = KM1_W'(k_eff - FLANK_W'(1));
  end

  assign hist_next = {code, base_history[CONTEXT_W-1:2]};
  assign amb_next  = {amb, ambig_history[HIST_BASES-1:1]};

  hpts_window u_left_win (
    .hist (base_history),
    .amb  (ambig_history),
    .k    (k_eff),
    .rev  (!amb && code[1]),
    .win  (left_win)
  );

  assign head_ent   = (pending_count == '0) ? new_ent :
                      (byp_sel ? byp_q : entry_t'(ram_q));
  assign head_valid = (pending_count != '0) || enq;
  assign elapsed    = step - head_ent.tag;
  assign pop        = accept && head_valid && (elapsed >= TAG_W'(head_ent.km1));

  hpts_window u_right_win (
    .hist (hist_next),
    .amb  (amb_next),
    .k    (k_eff),
    .rev  (head_ent.rev),
    .win  (right_win)
  );

  always_comb begin
    res.first  = head_ent.rev ? right_win : head_ent.left;
    res.second = head_ent.rev ? head_ent.left : right_win;
    res.base   = head_ent.base;
    res.length = head_ent.length;
    res.offset = head_ent.offset;
    res.rev    = head_ent.rev;
  end

  assign head_next  = flush ? '0 : (pop ? ptr_inc(head) : head);
  assign tail_next  = flush ? '0 : (enq ? ptr_inc(tail) : tail);
  assign count_next = flush ? '0 : pending_count + CW'(enq) - CW'(pop);

  hpts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PENDING_DEPTH),
    .AW    (AW)
  ) u_pending (
    .clk   (clk),
    .we    (enq),
    .waddr (tail),
    .wdata (new_ent),
    .raddr (head_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flank_bases   <= FLANK_BASES_RST;
      min_tract_len <= MIN_TRACT_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLANK_BASES:   flank_bases   <= cfg_data[FLANK_W-1:0];
        CFG_MIN_TRACT_LEN: min_tract_len <= cfg_data[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_history   <= '0;
      ambig_history  <= '0;
      position       <= '0;
      run_symbol     <= NO_SYMBOL;
      run_count      <= '0;
      run_start      <= '0;
      run_left_flank <= '0;
      head           <= '0;
      tail           <= '0;
      pending_count  <= '0;
      step           <= '0;
      byp_sel        <= 1'b0;
    end else begin
      byp_sel <= enq && (tail == head_next);
      if (accept) begin
        step          <= step + TAG_W'(1);
        head          <= head_next;
        tail          <= tail_next;
        pending_count <= count_next;
        if (flush) begin
          base_history   <= '0;
          ambig_history  <= '0;
          position       <= '0;
          run_symbol     <= NO_SYMBOL;
          run_count      <= '0;
          run_start      <= '0;
          run_left_flank <= '0;
        end else begin
          base_history  <= hist_next;
          ambig_history <= amb_next;
          if (position != '1) begin
            position <= position + POS_W'(1);
          end
          if (new_run) begin
            run_symbol     <= {1'b0, s_axis_tdata};
            run_count      <= LENGTH_W'(1);
            run_start      <= position;
            run_left_flank <= left_win;
          end else if (run_count != LENGTH_MAX) begin
            run_count <= run_count + LENGTH_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_q <= new_ent;
  end

  // hold the output word while stalled, park a new result in the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_axis_tready) begin
      if (pop) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_axis_tready) begin
      if (pop) begin
        skid_q <= res;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (pop) begin
      out_q <= res;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_q.offset, out_q.length, out_q.base,
                          out_q.second, out_q.first};
  assign m_axis_tuser  = out_q.rev;

endmodule

### bench/tb_homopolymer_tract_scanner_core.sv
`timescale 1ns / 1ps

module tb_homopolymer_tract_scanner_core;
  import hpts_pkg::*;

  localparam int PEND_DEPTH     = PENDING_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 40;

  localparam int FIRST_LSB  = 0;
  localparam int SECOND_LSB = 64;
  localparam int BASE_BIT   = 128;
  localparam int LENGTH_LSB = 129;
  localparam int OFFSET_LSB = 145;

  typedef struct {
    logic [SYMBOL_W-1:0] sym;
    logic                last;
  } word_t;

  typedef struct {
    logic [CONTEXT_W-1:0] left;
    int unsigned          length;
    int unsigned          offset;
    logic                 base;
    logic                 rev;
    int unsigned          remaining;
  } waiting_tract_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SYMBOL_W-1:0]    s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  homopolymer_tract_scanner_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner model state
  flank_t               flank_cfg = FLANK_BASES_RST;
  logic [MINLEN_W-1:0]  minlen_cfg = MIN_TRACT_LEN_RST;
  logic [CONTEXT_W-1:0] base_hist;
  amb_hist_t            amb_hist;
  int unsigned          read_pos;
  logic [SYMBOL_W:0]    run_sym;
  int unsigned          run_len;
  int unsigned          run_from;
  logic [CONTEXT_W-1:0] run_left;
  waiting_tract_t       waiting[PEND_DEPTH];
  int unsigned          wait_head;
  int unsigned          wait_count;
  result_t              expected_tracts[$];

  word_t       pending_words[$];
  word_t       offered;
  int unsigned words_queued = 0;
  int unsigned words_in = 0;
  int unsigned tracts_out = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holdoff_requests = 0;
  int unsigned holdoffs_taken = 0;
  int unsigned holdoff_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  logic [2:0]  rx_tick = '0;

  function automatic logic [1:0] base_code(input logic [SYMBOL_W-1:0] sym,
                                           output logic ambiguous);
    ambiguous = 1'b0;
    case (sym)
      "A", "a":           return BASE_A;
      "C", "c":           return BASE_C;
      "G", "g":           return BASE_G;
      "T", "t", "U", "u": return BASE_T;
      default: begin
        ambiguous = 1'b1;
        return BASE_A;
      end
    endcase
  endfunction

  function automatic int unsigned effective_flank();
    if (flank_cfg == 0) return 1;
    if (flank_cfg > MAX_FLANK) return MAX_FLANK;
    return flank_cfg;
  endfunction

  // last k bases, as read or reverse-complemented; ambiguous bases stay 0
  function automatic logic [CONTEXT_W-1:0] flank_window(int unsigned k, logic rc);
    logic [CONTEXT_W-1:0] fwd;
    logic [CONTEXT_W-1:0] out;
    amb_hist_t            amb;
    int unsigned          i;
    int unsigned          src;
    fwd = base_hist >> (64 - 2 * k);
    amb = amb_hist >> (32 - k);
    if (!rc) return fwd;
    out = '0;
    for (i = 0; i < k; i++) begin
      src = k - 1 - i;
      out[2*i +: 2] = amb[src] ? 2'd0 : 2'd3 - fwd[2*src +: 2];
    end
    return out;
  endfunction

  function automatic void clear_read();
    base_hist = '0;
    amb_hist = '0;
    read_pos = 0;
    run_sym = NO_SYMBOL;
    run_len = 0;
    run_from = 0;
    run_left = '0;
    wait_head = 0;
    wait_count = 0;
  endfunction

  function automatic void queue_tract(int unsigned k);
    logic           ambiguous;
    logic [1:0]     code;
    int unsigned    floor_len;
    waiting_tract_t t;
    if (run_sym == NO_SYMBOL) return;
    code = base_code(run_sym[SYMBOL_W-1:0], ambiguous);
    floor_len = (minlen_cfg < MIN_TRACT_FLOOR) ? MIN_TRACT_FLOOR : minlen_cfg;
    if (ambiguous || run_len < floor_len || run_from < k || wait_count >= PEND_DEPTH)
      return;
    t.left = run_left;
    t.length = run_len;
    t.offset = (run_from - k > 32'hFFFF) ? 32'hFFFF : run_from - k;
    t.rev = (code >= BASE_G);
    t.base = t.rev ? ~code[0] : code[0];
    t.remaining = k;
    waiting[(wait_head + wait_count) % PEND_DEPTH] = t;
    wait_count++;
  endfunction

  function automatic void scan_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
    int unsigned          k;
    int unsigned          i;
    int unsigned          slot;
    logic                 ambiguous;
    logic [1:0]           code;
    logic [CONTEXT_W-1:0] right;
    result_t              r;
    k = effective_flank();
    code = base_code(sym, ambiguous);
    if (run_sym != {1'b0, sym}) begin
      queue_tract(k);
      run_sym = {1'b0, sym};
      run_len = 1;
      run_from = read_pos;
      run_left = flank_window(k, !ambiguous && code >= BASE_G);
    end else if (run_len < LENGTH_MAX) begin
      run_len++;
    end
    base_hist = {code, base_hist[CONTEXT_W-1:2]};
    amb_hist = {ambiguous, amb_hist[HIST_BASES-1:1]};
    for (i = 0; i < wait_count; i++) begin
      slot = (wait_head + i) % PEND_DEPTH;
      if (waiting[slot].remaining > 0) waiting[slot].remaining--;
    end
    if (wait_count > 0 && waiting[wait_head].remaining == 0) begin
      right = flank_window(k, waiting[wait_head].rev);
      r.first = waiting[wait_head].rev ? right : waiting[wait_head].left;
      r.second = waiting[wait_head].rev ? waiting[wait_head].left : right;
      r.base = waiting[wait_head].base;
      r.length = waiting[wait_head].length[LENGTH_W-1:0];
      r.offset = waiting[wait_head].offset[OFFSET_W-1:0];
      r.rev = waiting[wait_head].rev;
      expected_tracts.push_back(r);
      wait_head = (wait_head + 1) % PEND_DEPTH;
      wait_count--;
    end
    if (read_pos != 32'hFFFF_FFFF) read_pos++;
    if (last) clear_read();
  endfunction

  function automatic void push_word(logic [SYMBOL_W-1:0] sym, logic last);
    word_t w;
    w.sym = sym;
    w.last = last;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_text(string text, logic close_read);
    int i;
    for (i = 0; i < text.len(); i++)
      push_word(text[i], close_read && i == text.len() - 1);
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    string       letters;
    int unsigned roll;
    letters = "ACGTUacgtu";
    roll = $urandom_range(0, 99);
    if (roll < 80) return letters[$urandom_range(0, 9)];
    if (roll < 90) return ($urandom_range(0, 1) != 0) ? "N" : "n";
    return SYMBOL_W'($urandom_range(0, 255));
  endfunction

  // runs of random symbols; pair_pct biases toward two-base runs
  function automatic void push_random_read(int unsigned len_lo, int unsigned len_hi,
                                           int unsigned run_hi, int unsigned pair_pct,
                                           logic close_read);
    int unsigned         len;
    int unsigned         n;
    int unsigned         run;
    int unsigned         i;
    logic [SYMBOL_W-1:0] sym;
    len = $urandom_range(len_lo, len_hi);
    n = 0;
    while (n < len) begin
      sym = pick_symbol();
      run = ($urandom_range(0, 99) < pair_pct) ? 2 : $urandom_range(1, run_hi);
      if (run > len - n) run = len - n;
      for (i = 0; i < run; i++) begin
        push_word(sym, close_read && n == len - 1);
        n++;
      end
    end
  endfunction

  function automatic void random_phase(int unsigned budget, int unsigned len_lo,
                                       int unsigned len_hi, int unsigned run_hi,
                                       int unsigned pair_pct);
    int unsigned start;
    start = words_queued;
    while (words_queued - start < budget)
      push_random_read(len_lo, len_hi, run_hi, pair_pct, 1'b1);
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_tracts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_FLANK_BASES) flank_cfg = value[FLANK_W-1:0];
    else minlen_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(int unsigned flank, int unsigned minlen);
    settle();
    write_register(CFG_FLANK_BASES, CFG_DATA_W'(flank));
    write_register(CFG_MIN_TRACT_LEN, CFG_DATA_W'(minlen));
  endtask

  function automatic void report_diff(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s expected %h actual %h", $time, field, want, got);
    end
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_symbol(offered.sym, offered.last);
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= offered.sym;
          s_axis_tlast <= offered.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off on request, else a changing stall pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 3'd1;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holdoffs_taken != holdoff_requests) begin
      holdoffs_taken <= holdoffs_taken + 1;
      holdoff_left <= HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(16, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
        2:       m_axis_tready <= (rx_tick[1:0] != 2'd3);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tracts_out++;
      if (expected_tracts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t tract expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_tracts.pop_front();
        report_diff("context_first", want.first, m_axis_tdata[FIRST_LSB +: CONTEXT_W]);
        report_diff("context_second", want.second, m_axis_tdata[SECOND_LSB +: CONTEXT_W]);
        report_diff("tract_base", want.base, m_axis_tdata[BASE_BIT]);
        report_diff("tract_len", want.length, m_axis_tdata[LENGTH_LSB +: LENGTH_W]);
        report_diff("flank_offset", want.offset, m_axis_tdata[OFFSET_LSB +: OFFSET_W]);
        report_diff("reverse_strand", want.rev, m_axis_tuser[0]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    clear_read();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    random_phase(150, 60, 120, 6, 20);

    reconfigure(2, 0);
    push_word(8'h00, 1'b0);
    push_text("CAAAGT", 1'b1);
    push_text("acggggUuuTa", 1'b1);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_text("..AAGGGC", 1'b1);

    reconfigure(1, 1);
    random_phase(200, 1, 30, 4, 30);
    holdoff_requests++;

    // two-base runs under a full-width flank fill the pending FIFO
    reconfigure(32, 2);
    random_phase(200, 70, 130, 2, 90);

    reconfigure(0, 255);
    push_random_read(10, 10, 3, 0, 1'b0);
    for (i = 0; i < 260; i++) push_word("C", 1'b0);
    push_text("GAT", 1'b1);
    random_phase(80, 1, 20, 4, 30);

    reconfigure(63, 3);
    random_phase(150, 60, 120, 6, 20);
    holdoff_requests++;

    reconfigure(5, 2);
    random_phase(150, 10, 60, 5, 30);

    // change the flank length in the middle of a read
    reconfigure(3, 2);
    push_random_read(30, 30, 4, 30, 1'b0);
    reconfigure(9, 2);
    push_random_read(40, 40, 4, 30, 1'b1);

    reconfigure(16, 6);
    random_phase(150, 40, 90, 9, 20);

    settle();
    repeat (32) @(negedge clk);
    $display("Scanned %0d words and checked %0d tracts across flank lengths 1 to 32,",
             words_in, tracts_out);
    $display("a mid-read flank change, a full pending FIFO and long output stalls.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
